### rtl/css_pkg.sv
// shared types, constants and helper function of the soft-start sequencer
`default_nettype none
package css_pkg;

	localparam int DUTY_W   = 16;
	localparam int INC_W    = 24;
	localparam int SUM_W    = ((DUTY_W > INC_W) ? DUTY_W : INC_W) + 1;
	localparam int PADDR_W  = 5;

	localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'({DUTY_W{1'b1}} & 32'h0000_ffff);
	localparam logic [15:0] SETTLE_RST     = 16'd20;
	localparam logic [7:0]  STEP_RST       = 8'd5;
	localparam logic signed [11:0] OTP_RST = 12'sd650;
	localparam logic [15:0] CNT_SAT        = 16'hffff;

	typedef enum logic [2:0] {
		REG_BUCK_MIN  = 3'd0,
		REG_BUCK_MAX  = 3'd1,
		REG_BOOST_MIN = 3'd2,
		REG_BOOST_MAX = 3'd3,
		REG_SETTLE    = 3'd4,
		REG_STEP      = 3'd5,
		REG_OTP       = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		M_INIT = 3'd0,
		M_WAIT = 3'd1,
		M_RISE = 3'd2,
		M_RUN  = 3'd3,
		M_ERR  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		S_INIT   = 2'd0,
		S_SETTLE = 2'd1,
		S_RAMP   = 2'd2
	} soft_t;

	typedef struct packed {
		logic [DUTY_W-1:0] buck_min;
		logic [DUTY_W-1:0] buck_max;
		logic [DUTY_W-1:0] boost_min;
		logic [DUTY_W-1:0] boost_max;
		logic [15:0]       settle_ticks;
		logic [7:0]        ramp_step;
		logic signed [11:0] otp_threshold;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		soft_t             soft_mode;
		logic              pwm_on;
		logic [15:0]       settle_count;
		logic [15:0]       ramp_count;
		logic [DUTY_W-1:0] buck_limit;
		logic [DUTY_W-1:0] boost_limit;
	} state_t;

	typedef struct packed {
		logic start_req;
		logic toggle_req;
		logic fault_active;
		logic signed [11:0] temperature;
	} tick_t;

	typedef struct packed {
		logic duty_preset;
		logic loop_clear;
		logic halve_ref;
	} pulse_t;

	// add the ramp increment and saturate at the maximum
	function automatic logic [DUTY_W-1:0] grow(input logic [DUTY_W-1:0] lim,
			input logic [INC_W-1:0] inc, input logic [DUTY_W-1:0] lmax);
		logic [SUM_W-1:0] s;
		s = SUM_W'(lim) + SUM_W'(inc);
		grow = (s > SUM_W'(lmax)) ? lmax : DUTY_W'(s);
	endfunction

endpackage
`default_nettype wire

### rtl/css_if.sv
// valid/ready channel interfaces for tick words and result words
`default_nettype none
interface css_tick_if;
	logic valid;
	logic ready;
	logic start_req;
	logic toggle_req;
	logic fault_active;
	logic signed [11:0] temperature;
	modport source (output valid, start_req, toggle_req, fault_active, temperature,
		input ready);
	modport sink (input valid, start_req, toggle_req, fault_active, temperature,
		output ready);
endinterface

interface css_result_if;
	logic valid;
	logic ready;
	logic [2:0]  main_state;
	logic [1:0]  soft_state;
	logic        pwm_enable;
	logic [15:0] buck_limit_out;
	logic [15:0] boost_limit_out;
	logic        duty_preset;
	logic        loop_clear;
	logic        halve_ref;
	modport source (output valid, main_state, soft_state, pwm_enable, buck_limit_out,
		boost_limit_out, duty_preset, loop_clear, halve_ref, input ready);
	modport sink (input valid, main_state, soft_state, pwm_enable, buck_limit_out,
		boost_limit_out, duty_preset, loop_clear, halve_ref, output ready);
endinterface
`default_nettype wire

### rtl/css_cfg.sv
// apb configuration register bank
`default_nettype none
module css_cfg
	import css_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buck_min      <= '0;
			cfg_q.buck_max      <= DUTY_MAX;
			cfg_q.boost_min     <= '0;
			cfg_q.boost_max     <= DUTY_MAX;
			cfg_q.settle_ticks  <= SETTLE_RST;
			cfg_q.ramp_step     <= STEP_RST;
			cfg_q.otp_threshold <= OTP_RST;
		end else if (wr) begin
			case (idx)
				REG_BUCK_MIN:  cfg_q.buck_min      <= DUTY_W'(pwdata[15:0]);
				REG_BUCK_MAX:  cfg_q.buck_max      <= DUTY_W'(pwdata[15:0]);
				REG_BOOST_MIN: cfg_q.boost_min     <= DUTY_W'(pwdata[15:0]);
				REG_BOOST_MAX: cfg_q.boost_max     <= DUTY_W'(pwdata[15:0]);
				REG_SETTLE:    cfg_q.settle_ticks  <= pwdata[15:0];
				REG_STEP:      cfg_q.ramp_step     <= pwdata[7:0];
				REG_OTP:       cfg_q.otp_threshold <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BUCK_MIN:  prdata = 32'(cfg_q.buck_min);
			REG_BUCK_MAX:  prdata = 32'(cfg_q.buck_max);
			REG_BOOST_MIN: prdata = 32'(cfg_q.boost_min);
			REG_BOOST_MAX: prdata = 32'(cfg_q.boost_max);
			REG_SETTLE:    prdata = 32'(cfg_q.settle_ticks);
			REG_STEP:      prdata = 32'(cfg_q.ramp_step);
			REG_OTP:       prdata = {{20{cfg_q.otp_threshold[11]}}, cfg_q.otp_threshold};
			default:       prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/css_step.sv
// next-state and pulse logic for one control tick
`default_nettype none
module css_step
	import css_pkg::*;
(
	input  tick_t  tick,
	input  state_t cur,
	input  cfg_t   cfg,
	output state_t nxt,
	output pulse_t pulse
);

	mode_t            mode_pre;
	logic             pwm_pre;
	logic [16:0]      settle_inc;
	logic             settle_done;
	logic [15:0]      rc_inc;
	logic [INC_W-1:0] inc;
	logic [DUTY_W-1:0] buck_g, boost_g;

	// requests and protection, applied before the state action
	always_comb begin
		mode_pre = cur.mode;
		pwm_pre  = cur.pwm_on;
		if (tick.toggle_req) begin
			if (cur.mode == M_RISE || cur.mode == M_RUN) begin
				mode_pre = M_WAIT;
				pwm_pre  = 1'b0;
			end else if (cur.mode == M_WAIT) begin
				mode_pre = M_RUN;
				pwm_pre  = 1'b1;
			end
		end
		if (tick.start_req && mode_pre == M_WAIT) mode_pre = M_RISE;
		if (tick.temperature >= cfg.otp_threshold) begin
			mode_pre = M_WAIT;
			pwm_pre  = 1'b0;
		end
		if (tick.fault_active) mode_pre = M_ERR;
	end

	assign settle_inc  = 17'(cur.settle_count) + 17'd1;
	assign settle_done = settle_inc > 17'(cfg.settle_ticks);
	assign rc_inc      = (cur.ramp_count < CNT_SAT) ? cur.ramp_count + 16'd1 : cur.ramp_count;
	assign inc         = INC_W'(rc_inc) * INC_W'(cfg.ramp_step);
	assign buck_g      = grow(cur.buck_limit, inc, cfg.buck_max);
	assign boost_g     = grow(cur.boost_limit, inc, cfg.boost_max);

	// next state
	always_comb begin
		nxt        = cur;
		nxt.mode   = mode_pre;
		nxt.pwm_on = pwm_pre;
		case (mode_pre)
			M_INIT: begin
				nxt.pwm_on      = 1'b0;
				nxt.buck_limit  = cfg.buck_min;
				nxt.boost_limit = cfg.boost_min;
				nxt.mode        = M_WAIT;
			end
			M_RISE: begin
				case (cur.soft_mode)
					S_INIT: begin
						nxt.pwm_on      = 1'b0;
						nxt.buck_limit  = cfg.buck_min;
						nxt.boost_limit = cfg.boost_min;
						nxt.ramp_count  = '0;
						nxt.soft_mode   = S_SETTLE;
					end
					S_SETTLE: begin
						if (settle_done) begin
							nxt.settle_count = '0;
							nxt.buck_limit   = cfg.buck_min;
							nxt.boost_limit  = cfg.boost_min;
							nxt.ramp_count   = '0;
							nxt.soft_mode    = S_RAMP;
						end else begin
							nxt.settle_count = settle_inc[15:0];
						end
					end
					S_RAMP: begin
						nxt.pwm_on      = 1'b1;
						nxt.ramp_count  = rc_inc;
						nxt.buck_limit  = buck_g;
						nxt.boost_limit = boost_g;
						if (buck_g == cfg.buck_max && boost_g == cfg.boost_max) begin
							nxt.mode      = M_RUN;
							nxt.soft_mode = S_INIT;
						end
					end
					default: nxt.soft_mode = S_INIT;
				endcase
			end
			M_ERR: begin
				nxt.pwm_on = 1'b0;
				if (!tick.fault_active) nxt.mode = M_WAIT;
			end
			default: ;
		endcase
	end

	// one-tick pulses
	always_comb begin
		pulse = '0;
		case (mode_pre)
			M_INIT: begin
				pulse.duty_preset = 1'b1;
				pulse.loop_clear  = 1'b1;
			end
			M_RISE: begin
				case (cur.soft_mode)
					S_INIT:   pulse.loop_clear = 1'b1;
					S_SETTLE: begin
						if (settle_done) begin
							pulse.duty_preset = 1'b1;
							pulse.loop_clear  = 1'b1;
							pulse.halve_ref   = 1'b1;
						end
					end
					S_RAMP:   pulse.loop_clear = !pwm_pre;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### rtl/converter_soft_start_sequencer_core.sv
// top level of the converter soft-start sequencer
// Soft-start sequencer for a buck-boost power stage. Every tick word carries
// the start and run/stop key requests, the fault flag and the heatsink
// temperature; each accepted tick yields exactly one result word with the main
// state, the soft-start state, the pwm enable, both duty limits and the
// preset / loop-clear / halve-reference pulses. A tick is captured in an input
// register, the state update runs through one short combinational pass (the
// 16x8 ramp multiply, the limit add and saturate are the longest path) and the
// state and pulse registers load together with the result word. Throughput is
// one tick per cycle while results are taken; each result word loads from the
// input register once the result slot is free. A waiting result still lets one
// more tick into the input register; the next waits until the result is taken.
// Configuration goes through a 32-bit apb port with registers at byte address
// 4*index; writes are expected only while no tick is in flight.
`default_nettype none
module converter_soft_start_sequencer_core
	import css_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	css_tick_if.sink                tick,
	css_result_if.source            result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	cfg_t   cfg;
	tick_t  tick_s1;
	logic   valid_s1;
	state_t state_q, state_nxt;
	pulse_t pulse_q, pulse_nxt;
	logic   out_valid_q;
	logic   advance;

	css_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the captured tick moves on once the result slot is free or being drained
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			tick_s1.start_req    <= tick.start_req;
			tick_s1.toggle_req   <= tick.toggle_req;
			tick_s1.fault_active <= tick.fault_active;
			tick_s1.temperature  <= tick.temperature;
		end
	end

	css_step u_step (
		.tick  (tick_s1),
		.cur   (state_q),
		.cfg   (cfg),
		.nxt   (state_nxt),
		.pulse (pulse_nxt)
	);

	// sequencer state doubles as the result payload; it only changes when a
	// new result is loaded, so a stalled word holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= M_INIT;
			state_q.soft_mode    <= S_INIT;
			state_q.pwm_on       <= 1'b0;
			state_q.settle_count <= '0;
			state_q.ramp_count   <= '0;
			state_q.buck_limit   <= '0;
			state_q.boost_limit  <= '0;
			pulse_q              <= '0;
			out_valid_q          <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				pulse_q     <= pulse_nxt;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.main_state      = state_q.mode;
	assign result.soft_state      = state_q.soft_mode;
	assign result.pwm_enable      = state_q.pwm_on;
	assign result.buck_limit_out  = 16'(state_q.buck_limit);
	assign result.boost_limit_out = 16'(state_q.boost_limit);
	assign result.duty_preset     = pulse_q.duty_preset;
	assign result.loop_clear      = pulse_q.loop_clear;
	assign result.halve_ref       = pulse_q.halve_ref;

endmodule
`default_nettype wire
